### design/mi3_pkg.sv
// package: widths, word types and cofactor tables for the 3x3 fixed-point inverse
package mi3_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int N_ELEM = 9;
  localparam int N_DET = 3;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int COF_BITS = PROD_BITS + 1;
  localparam int PP_BITS = 2 * WORD_BITS + 1;
  localparam int TERM_BITS = 3 * WORD_BITS + 1;
  localparam int DET_BITS = TERM_BITS + 2;
  localparam int SCALED_BITS = COF_BITS + 2 * FRAC_BITS;
  localparam int NUM_BITS =
    ((SCALED_BITS + 1 > DET_BITS) ? SCALED_BITS + 1 : DET_BITS) + 1;
  localparam int QUOT_BITS = WORD_BITS + 2;
  localparam int CMP_BITS = NUM_BITS + QUOT_BITS;

  typedef logic signed [WORD_BITS-1:0] elem_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [COF_BITS-1:0] cof_t;
  typedef logic signed [PP_BITS-1:0] pp_t;
  typedef logic signed [TERM_BITS-1:0] term_t;
  typedef logic signed [DET_BITS-1:0] det_t;
  typedef logic [NUM_BITS-1:0] num_t;
  typedef logic [CMP_BITS-1:0] cmp_t;
  typedef logic [QUOT_BITS-1:0] quot_t;

  localparam elem_t ONE = elem_t'(1) << FRAC_BITS;
  localparam quot_t Q_LIM = quot_t'(1) << (WORD_BITS - 1);

  // cofactor k = m[a] * m[b] - m[c] * m[d]
  localparam int COF_SEL [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };
  // cofactors paired with the top row for the determinant
  localparam int DET_SEL [N_DET] = '{0, 3, 6};

  typedef struct packed {
    elem_t elem_r0c0;
    elem_t elem_r0c1;
    elem_t elem_r0c2;
    elem_t elem_r1c0;
    elem_t elem_r1c1;
    elem_t elem_r1c2;
    elem_t elem_r2c0;
    elem_t elem_r2c1;
    elem_t elem_r2c2;
  } mat_word_t;

  typedef struct packed {
    elem_t inv_r0c0;
    elem_t inv_r0c1;
    elem_t inv_r0c2;
    elem_t inv_r1c0;
    elem_t inv_r1c1;
    elem_t inv_r1c2;
    elem_t inv_r2c0;
    elem_t inv_r2c1;
    elem_t inv_r2c2;
    logic singular;
    logic overflowed;
  } inv_word_t;

endpackage

### design/matrix3_inverse_top.sv
// top level: pipelined 3x3 matrix inverse in signed fixed point
//
// usage
// - mat channel takes one word per cycle while not stalled: nine signed
//   fixed-point elements of a 3x3 matrix, row-major; inv channel returns one
//   word per matrix with the nine inverse elements, singular and overflowed
// - a word is taken on a rising edge with valid high and stall low
// - the pipeline has 2 product/cofactor stages, 3 determinant stages,
//   1 magnitude stage, 34 restoring-divider stages (one quotient bit per
//   stage, nine lanes sharing one divisor) and the saturating output register
// - throughput: one matrix per cycle unless stalled; divider pipeline sets depth
// - each element is cofactor * 2^(2*frac) / det, rounded to nearest with
//   ties away from zero, saturated to the word range (sets overflowed)
// - zero determinant gives the identity with singular set
// - reset clears all valid bits; payload registers are not reset
// - when the receiver stalls a held result, the whole pipeline freezes and
//   mat_stall rises in the same cycle, so nothing is lost or repeated
module matrix3_inverse_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                mat_valid,
  output logic                mat_stall,
  input  mi3_pkg::mat_word_t  mat,
  output logic                inv_valid,
  input  logic                inv_stall,
  output mi3_pkg::inv_word_t  inv
);

  localparam int NE = mi3_pkg::N_ELEM;
  localparam int ND = mi3_pkg::N_DET;
  localparam int W = mi3_pkg::WORD_BITS;
  localparam int QB = mi3_pkg::QUOT_BITS;

  // whole pipeline moves unless the output word is held
  logic adv;
  assign adv = !(inv_valid && inv_stall);
  assign mat_stall = !adv;

  // unpack input word
  mi3_pkg::elem_t m_in [NE];
  assign m_in[0] = mat.elem_r0c0;
  assign m_in[1] = mat.elem_r0c1;
  assign m_in[2] = mat.elem_r0c2;
  assign m_in[3] = mat.elem_r1c0;
  assign m_in[4] = mat.elem_r1c1;
  assign m_in[5] = mat.elem_r1c2;
  assign m_in[6] = mat.elem_r2c0;
  assign m_in[7] = mat.elem_r2c1;
  assign m_in[8] = mat.elem_r2c2;

  // stage 1: eighteen 2x2 minor products
  logic v1;
  mi3_pkg::prod_t s1_pa [NE];
  mi3_pkg::prod_t s1_pb [NE];
  mi3_pkg::elem_t s1_top [ND];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= mat_valid;
    end
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        s1_pa[k] <= m_in[mi3_pkg::COF_SEL[k][0]] * m_in[mi3_pkg::COF_SEL[k][1]];
        s1_pb[k] <= m_in[mi3_pkg::COF_SEL[k][2]] * m_in[mi3_pkg::COF_SEL[k][3]];
      end
      for (int j = 0; j < ND; j++) begin
        s1_top[j] <= m_in[j];
      end
    end
  end

  // stage 2: cofactors
  logic v2;
  mi3_pkg::cof_t s2_cof [NE];
  mi3_pkg::elem_t s2_top [ND];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        s2_cof[k] <= mi3_pkg::cof_t'(s1_pa[k]) - mi3_pkg::cof_t'(s1_pb[k]);
      end
      for (int j = 0; j < ND; j++) begin
        s2_top[j] <= s1_top[j];
      end
    end
  end

  // stage 3: top row times cofactor, split in a low and a high half
  logic v3;
  mi3_pkg::pp_t s3_lo [ND];
  mi3_pkg::pp_t s3_hi [ND];
  mi3_pkg::cof_t s3_cof [NE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      for (int j = 0; j < ND; j++) begin
        s3_lo[j] <= s2_top[j] * $signed({1'b0, s2_cof[mi3_pkg::DET_SEL[j]][W-1:0]});
        s3_hi[j] <= s2_top[j]
                    * $signed(s2_cof[mi3_pkg::DET_SEL[j]][mi3_pkg::COF_BITS-1:W]);
      end
      s3_cof <= s2_cof;
    end
  end

  // stage 4: recombine halves
  logic v4;
  mi3_pkg::term_t s4_term [ND];
  mi3_pkg::cof_t s4_cof [NE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      for (int j = 0; j < ND; j++) begin
        s4_term[j] <= (mi3_pkg::term_t'(s3_hi[j]) <<< W) + mi3_pkg::term_t'(s3_lo[j]);
      end
      s4_cof <= s3_cof;
    end
  end

  // stage 5: determinant
  logic v5;
  mi3_pkg::det_t s5_det;
  mi3_pkg::cof_t s5_cof [NE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      s5_det <= mi3_pkg::det_t'(s4_term[0]) + mi3_pkg::det_t'(s4_term[1])
                + mi3_pkg::det_t'(s4_term[2]);
      s5_cof <= s4_cof;
    end
  end

  // stage 6: magnitudes; numerator 2*|cof|*2^(2f) + |det|, divisor 2*|det|
  // gives the rounded quotient directly
  mi3_pkg::det_t det_negated;
  logic [mi3_pkg::DET_BITS-1:0] det_mag;
  logic [mi3_pkg::COF_BITS-1:0] cof_mag [NE];
  mi3_pkg::num_t num_val [NE];

  always_comb begin
    det_negated = -s5_det;
    det_mag = s5_det[mi3_pkg::DET_BITS-1] ? det_negated : s5_det;
    for (int k = 0; k < NE; k++) begin
      cof_mag[k] = s5_cof[k][mi3_pkg::COF_BITS-1] ? -s5_cof[k] : s5_cof[k];
      num_val[k] = (mi3_pkg::num_t'({cof_mag[k], {(2 * mi3_pkg::FRAC_BITS){1'b0}}}) << 1)
                   + mi3_pkg::num_t'(det_mag);
    end
  end

  // divider pipeline; index 0 is the magnitude stage
  logic [QB:0] dv_v;
  mi3_pkg::num_t dv_rem [QB+1][NE];
  mi3_pkg::quot_t dv_quot [QB+1][NE];
  logic [NE-1:0] dv_neg [QB+1];
  mi3_pkg::num_t dv_den [QB+1];
  logic dv_sing [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= v5;
    end
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        dv_rem[0][k] <= num_val[k];
        dv_quot[0][k] <= '0;
        dv_neg[0][k] <= s5_cof[k][mi3_pkg::COF_BITS-1] ^ s5_det[mi3_pkg::DET_BITS-1];
      end
      dv_den[0] <= mi3_pkg::num_t'(det_mag) << 1;
      dv_sing[0] <= (s5_det == '0);
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int BIT = QB - s;
    mi3_pkg::cmp_t shifted;
    mi3_pkg::cmp_t diff [NE];
    logic [NE-1:0] ge;

    assign shifted = mi3_pkg::cmp_t'(dv_den[s-1]) << BIT;
    for (genvar k = 0; k < NE; k++) begin : g_lane
      assign diff[k] = mi3_pkg::cmp_t'(dv_rem[s-1][k]) - shifted;
      assign ge[k] = mi3_pkg::cmp_t'(dv_rem[s-1][k]) >= shifted;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[s] <= 1'b0;
      end else if (adv) begin
        dv_v[s] <= dv_v[s-1];
      end
      if (adv) begin
        for (int k = 0; k < NE; k++) begin
          dv_rem[s][k] <= ge[k] ? diff[k][mi3_pkg::NUM_BITS-1:0] : dv_rem[s-1][k];
          dv_quot[s][k] <= dv_quot[s-1][k] | (mi3_pkg::quot_t'(ge[k]) << BIT);
        end
        dv_neg[s] <= dv_neg[s-1];
        dv_den[s] <= dv_den[s-1];
        dv_sing[s] <= dv_sing[s-1];
      end
    end
  end

  // sign, saturation and identity for a singular matrix
  mi3_pkg::elem_t res [NE];
  mi3_pkg::elem_t mag [NE];
  logic [NE-1:0] over;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (dv_neg[QB][k]) begin
        over[k] = dv_quot[QB][k] > mi3_pkg::Q_LIM;
        mag[k] = over[k] ? mi3_pkg::elem_t'(mi3_pkg::Q_LIM) : dv_quot[QB][k][W-1:0];
        res[k] = -mag[k];
      end else begin
        over[k] = dv_quot[QB][k] > (mi3_pkg::Q_LIM - 1'b1);
        mag[k] = over[k] ? mi3_pkg::elem_t'(mi3_pkg::Q_LIM - 1'b1)
                         : dv_quot[QB][k][W-1:0];
        res[k] = mag[k];
      end
      if (dv_sing[QB]) begin
        res[k] = (k == 0 || k == 4 || k == 8) ? mi3_pkg::ONE : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
    end else if (adv) begin
      inv_valid <= dv_v[QB];
    end
    if (adv) begin
      inv.inv_r0c0 <= res[0];
      inv.inv_r0c1 <= res[1];
      inv.inv_r0c2 <= res[2];
      inv.inv_r1c0 <= res[3];
      inv.inv_r1c1 <= res[4];
      inv.inv_r1c2 <= res[5];
      inv.inv_r2c0 <= res[6];
      inv.inv_r2c1 <= res[7];
      inv.inv_r2c2 <= res[8];
      inv.singular <= dv_sing[QB];
      inv.overflowed <= !dv_sing[QB] && (over != '0);
    end
  end

  // input backs up only behind a held output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    mat_stall |-> (inv_valid && inv_stall))
    else $error("input stalled without a held output");

  // a taken word with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (inv_valid && !inv_stall && !dv_v[QB]) |=> !inv_valid)
    else $error("output word repeated");

  // zero divisor only for a singular matrix
  a_den_zero: assert property (@(posedge clk) disable iff (rst)
    (dv_v[QB] && dv_den[QB] == '0) |-> dv_sing[QB])
    else $error("zero divisor on a regular matrix");

  // singular result shows identity entries r1c1 and r0c1 and never flags overflow
  a_singular: assert property (@(posedge clk) disable iff (rst)
    (inv_valid && inv.singular) |-> (!inv.overflowed && inv.inv_r1c1 == mi3_pkg::ONE
                                     && inv.inv_r0c1 == '0))
    else $error("singular result malformed");

endmodule
